// ===== src/pat_pkg.sv =====
`timescale 1ns / 1ps

package pat_pkg;

    // Field widths of one sighting word
    localparam int ADDR_W     = 48;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 48;
    localparam int INTERVAL_W = 16;
    localparam int OUT_IDX_W  = 6;

    // Throttle interval after reset, in ms
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd200;

    // One table slot as kept in the slot memory
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] last_time;
        logic              named;
    } slot_t;

endpackage

// ===== src/per_address_report_throttle.sv =====
`timescale 1ns / 1ps

// Channel    | Ports                                              | Handshake
// -----------+----------------------------------------------------+-------------------------
// sighting   | device_address, address_kind, name_present,        | start & !busy
//            | now_time                                           |
// result     | allow, found, evicted, slot_index                  | done, one cycle
// config     | cfg_wdata                                          | cfg_we
//
// From acceptance to done a sighting first scans the used slots for its address. When it
// is found, the slot is checked and, unless suppressed, rewritten; else the lowest free
// slot is taken, or, when the table is full, all slots are scanned and the oldest replaced.
// The scans are set by the single read port of the slot memory, one slot per cycle.
// Reset clears the fill count and the state machine; slot contents need no reset.
// The result is not held: done is high for one cycle and results cannot be stalled.
module per_address_report_throttle #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pat_pkg::ADDR_W-1:0]        device_address,
    input  logic [pat_pkg::KIND_W-1:0]        address_kind,
    input  logic                              name_present,
    input  logic [pat_pkg::TIME_W-1:0]        now_time,
    input  logic                              cfg_we,
    input  logic [pat_pkg::INTERVAL_W-1:0]    cfg_wdata,
    output logic                              done,
    output logic                              allow,
    output logic                              found,
    output logic                              evicted,
    output logic [pat_pkg::OUT_IDX_W-1:0]     slot_index
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_OLDEST,
        ST_WRITE
    } state_t;

    state_t                          state_reg, state_next;
    logic [pat_pkg::INTERVAL_W-1:0]  interval_reg;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic                            pend_reg, pend_next;
    logic [IDX_W-1:0]                pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]                pick_reg, pick_next;
    logic [pat_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [pat_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic                            named_reg, named_next;
    logic [pat_pkg::TIME_W-1:0]      now_reg, now_next;
    logic                            hit_named_reg, hit_named_next;
    logic [pat_pkg::TIME_W-1:0]      hit_time_reg, hit_time_next;
    logic                            wnamed_reg, wnamed_next;
    logic [pat_pkg::TIME_W-1:0]      min_time_reg, min_time_next;
    logic                            done_reg, done_next;
    logic                            allow_reg, allow_next;
    logic                            found_reg, found_next;
    logic                            evicted_reg, evicted_next;

    // Slot memory: one write, one registered read per cycle
    pat_pkg::slot_t                  mem [SLOT_COUNT];
    pat_pkg::slot_t                  rdata_reg;
    pat_pkg::slot_t                  mem_wdata;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_raddr;

    logic                            hit;
    logic [pat_pkg::TIME_W-1:0]      diff;
    logic                            too_soon;
    logic                            first_name;
    logic [IDX_W+pat_pkg::OUT_IDX_W-1:0] slot_wide;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pick_reg] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign mem_raddr = idx_reg[IDX_W-1:0];
    assign mem_we    = (state_reg == ST_WRITE);
    assign mem_wdata = '{addr: addr_reg, kind: kind_reg, last_time: now_reg,
                         named: wnamed_reg};

    // Match on the word coming back from the memory
    assign hit = pend_reg && (rdata_reg.addr == addr_reg) && (rdata_reg.kind == kind_reg);

    // Signed time since the last pass against the interval
    assign diff       = now_reg - hit_time_reg;
    assign too_soon   = diff[pat_pkg::TIME_W-1]
                        || (diff < pat_pkg::TIME_W'(interval_reg));
    assign first_name = named_reg && !hit_named_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        pick_next      = pick_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        named_next     = named_reg;
        now_next       = now_reg;
        hit_named_next = hit_named_reg;
        hit_time_next  = hit_time_reg;
        wnamed_next    = wnamed_reg;
        min_time_next  = min_time_reg;
        done_next      = 1'b0;
        allow_next     = allow_reg;
        found_next     = found_reg;
        evicted_next   = evicted_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next  = device_address;
                    kind_next  = address_kind;
                    named_next = name_present;
                    now_next   = now_time;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            // First pass: look for the address over the used slots
            ST_SCAN:
            begin
                if (hit)
                begin
                    hit_named_next = rdata_reg.named;
                    hit_time_next  = rdata_reg.last_time;
                    pick_next      = pend_idx_reg;
                    pend_next      = 1'b0;
                    state_next     = ST_CHECK;
                end
                else if (idx_reg < fill_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else if (fill_reg < CNT_W'(SLOT_COUNT))
                begin
                    // New address, lowest free slot
                    pend_next    = 1'b0;
                    pick_next    = fill_reg[IDX_W-1:0];
                    fill_next    = fill_reg + 1'b1;
                    wnamed_next  = named_reg;
                    allow_next   = 1'b1;
                    found_next   = 1'b0;
                    evicted_next = 1'b0;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    // Table full, go find the oldest slot
                    pend_next  = 1'b0;
                    idx_next   = '0;
                    state_next = ST_OLDEST;
                end
            end

            ST_CHECK:
            begin
                found_next   = 1'b1;
                evicted_next = 1'b0;
                if (!first_name && too_soon)
                begin
                    allow_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    allow_next  = 1'b1;
                    wnamed_next = hit_named_reg || named_reg;
                    state_next  = ST_WRITE;
                end
            end

            // Second pass: smallest last time, lowest index on ties
            ST_OLDEST:
            begin
                if (pend_reg)
                begin
                    if ((pend_idx_reg == '0) || (rdata_reg.last_time < min_time_reg))
                    begin
                        min_time_next = rdata_reg.last_time;
                        pick_next     = pend_idx_reg;
                    end
                end
                if (idx_reg < CNT_W'(SLOT_COUNT))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        wnamed_next  = named_reg;
                        allow_next   = 1'b1;
                        found_next   = 1'b0;
                        evicted_next = 1'b1;
                        state_next   = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            interval_reg <= pat_pkg::INTERVAL_RESET;
            fill_reg     <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            pick_reg     <= '0;
            allow_reg    <= 1'b0;
            found_reg    <= 1'b0;
            evicted_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            pick_reg    <= pick_next;
            allow_reg   <= allow_next;
            found_reg   <= found_next;
            evicted_reg <= evicted_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        addr_reg      <= addr_next;
        kind_reg      <= kind_next;
        named_reg     <= named_next;
        now_reg       <= now_next;
        hit_named_reg <= hit_named_next;
        hit_time_reg  <= hit_time_next;
        wnamed_reg    <= wnamed_next;
        min_time_reg  <= min_time_next;
    end

    // Result word; slot number reported modulo 64
    assign slot_wide  = {{pat_pkg::OUT_IDX_W{1'b0}}, pick_reg};
    assign slot_index = slot_wide[pat_pkg::OUT_IDX_W-1:0];
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign allow      = allow_reg;
    assign found      = found_reg;
    assign evicted    = evicted_reg;

endmodule

// ===== bench/per_address_report_throttle_test.sv =====
`timescale 1ns / 1ps

module per_address_report_throttle_test;

    localparam int SLOT_COUNT      = 64;
    localparam int POOL_SIZE       = 160;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int PHASE_COUNT     = 5;
    localparam int PHASE_ITEMS     = 160;

    localparam logic [pat_pkg::TIME_W-1:0] HALF_RANGE = 48'h8000_0000_0000;
    localparam logic [pat_pkg::ADDR_W-1:0] ADDR_ONES  = 48'hFFFF_FFFF_FFFF;

    // One result word: verdict plus slot
    typedef struct packed {
        logic                          allow;
        logic                          found;
        logic                          evicted;
        logic [pat_pkg::OUT_IDX_W-1:0] slot;
    } verdict_t;

    // Mirror of the slot table; predicts the verdict for each sighting
    class throttle_scoreboard;
        logic [pat_pkg::INTERVAL_W-1:0] interval;
        bit                             used     [SLOT_COUNT];
        logic [pat_pkg::ADDR_W-1:0]     addr_tab [SLOT_COUNT];
        logic [pat_pkg::KIND_W-1:0]     kind_tab [SLOT_COUNT];
        logic [pat_pkg::TIME_W-1:0]     time_tab [SLOT_COUNT];
        logic                           named_tab[SLOT_COUNT];
        verdict_t                       verdict_q[$];
        int                             fails;

        function new();
            interval = pat_pkg::INTERVAL_RESET;
            fails    = 0;
            foreach (used[i])
                used[i] = 1'b0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Predict the verdict of one accepted sighting and update the table
        function void note_sighting(logic [pat_pkg::ADDR_W-1:0] a,
                                    logic [pat_pkg::KIND_W-1:0] k,
                                    logic nm, logic [pat_pkg::TIME_W-1:0] now);
            int                         pick;
            bit                         have_free;
            bit                         first_name;
            bit                         too_soon;
            logic [pat_pkg::TIME_W-1:0] diff;
            logic [pat_pkg::TIME_W-1:0] oldest;
            verdict_t                   v;
            pick      = 0;
            have_free = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (!used[i])
                begin
                    if (!have_free)
                    begin
                        have_free = 1'b1;
                        pick      = i;
                    end
                    continue;
                end
                if (addr_tab[i] == a && kind_tab[i] == k)
                begin
                    first_name = nm && !named_tab[i];
                    diff       = now - time_tab[i];
                    // negative difference (time went back) counts as too soon
                    too_soon   = diff[pat_pkg::TIME_W-1] || (diff < {32'd0, interval});
                    v.found    = 1'b1;
                    v.evicted  = 1'b0;
                    v.slot     = i[pat_pkg::OUT_IDX_W-1:0];
                    if (!first_name && too_soon)
                        v.allow = 1'b0;
                    else
                    begin
                        v.allow     = 1'b1;
                        time_tab[i] = now;
                        if (nm)
                            named_tab[i] = 1'b1;
                    end
                    verdict_q.push_back(v);
                    return;
                end
            end
            // new address: lowest free slot, else oldest time, lowest index on ties
            v.evicted = 1'b0;
            if (!have_free)
            begin
                oldest = time_tab[0];
                pick   = 0;
                for (int i = 1; i < SLOT_COUNT; i++)
                begin
                    if (time_tab[i] < oldest)
                    begin
                        oldest = time_tab[i];
                        pick   = i;
                    end
                end
                v.evicted = 1'b1;
            end
            used[pick]      = 1'b1;
            addr_tab[pick]  = a;
            kind_tab[pick]  = k;
            time_tab[pick]  = now;
            named_tab[pick] = nm;
            v.allow = 1'b1;
            v.found = 1'b0;
            v.slot  = pick[pat_pkg::OUT_IDX_W-1:0];
            verdict_q.push_back(v);
        endfunction

        // Compare one result word with the oldest prediction
        function void check_result(logic al, logic fd, logic ev,
                                   logic [pat_pkg::OUT_IDX_W-1:0] idx);
            verdict_t got;
            verdict_t want;
            got = {al, fd, ev, idx};
            if (verdict_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: word with nothing pending: allow=%b found=%b %s%b slot=%0d",
                             al, fd, "evicted=", ev, idx);
                return;
            end
            want = verdict_q.pop_front();
            if (got !== want)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("mismatch: expected allow=%b found=%b evicted=%b slot=%0d",
                             want.allow, want.found, want.evicted, want.slot);
                    $display("          got      allow=%b found=%b evicted=%b slot=%0d",
                             al, fd, ev, idx);
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [pat_pkg::ADDR_W-1:0]     device_address;
    logic [pat_pkg::KIND_W-1:0]     address_kind;
    logic                           name_present;
    logic [pat_pkg::TIME_W-1:0]     now_time;
    logic                           cfg_we;
    logic [pat_pkg::INTERVAL_W-1:0] cfg_wdata;
    logic                           done;
    logic                           allow;
    logic                           found;
    logic                           evicted;
    logic [pat_pkg::OUT_IDX_W-1:0]  slot_index;

    throttle_scoreboard sb = new();

    logic [pat_pkg::ADDR_W-1:0] pool_addr[POOL_SIZE];
    logic [pat_pkg::KIND_W-1:0] pool_kind[POOL_SIZE];
    logic [pat_pkg::TIME_W-1:0] now_ms;
    int                         quiet_cycles;

    per_address_report_throttle #(
        .SLOT_COUNT(SLOT_COUNT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .device_address(device_address),
        .address_kind  (address_kind),
        .name_present  (name_present),
        .now_time      (now_time),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .allow         (allow),
        .found         (found),
        .evicted       (evicted),
        .slot_index    (slot_index)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Monitor: accepted sightings, result words, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                sb.check_result(allow, found, evicted, slot_index);
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                sb.note_sighting(device_address, address_kind, name_present, now_time);
            end
            if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Present one sighting word and hold it until accepted
    task automatic send_sighting(input logic [pat_pkg::ADDR_W-1:0] a,
                                 input logic [pat_pkg::KIND_W-1:0] k,
                                 input logic nm, input logic [pat_pkg::TIME_W-1:0] t);
        start          <= 1'b1;
        device_address <= a;
        address_kind   <= k;
        name_present   <= nm;
        now_time       <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Sender idles each cycle with the given chance in percent
    task automatic sender_gap(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Hold off until every predicted word has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0 || busy !== 1'b0);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_interval(input logic [pat_pkg::INTERVAL_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.interval = v;
        @(negedge clk);
    endtask

    // Move the sighting clock: mostly forward, sometimes back or far ahead
    task automatic advance_clock();
        int iv;
        int roll;
        iv   = int'(sb.interval);
        roll = $urandom_range(0, 99);
        if (roll < 25)
            now_ms = now_ms;
        else if (roll < 70)
            now_ms = now_ms + $urandom_range(0, iv / 2 + 2);
        else if (roll < 93)
            now_ms = now_ms + $urandom_range(iv / 2, 2 * iv + 3);
        else if (roll < 97)
            now_ms = now_ms - $urandom_range(1, iv + 5);
        else if (roll < 99)
            now_ms = now_ms + $urandom_range(iv * 4, iv * 40 + 1000);
        else
            now_ms = now_ms + HALF_RANGE;
    endtask

    // Mostly addresses from a pool (hits, throttling, eviction), some fresh noise
    task automatic send_random_sighting(input int pool_n);
        int                         p;
        logic [63:0]                wide;
        logic [pat_pkg::ADDR_W-1:0] a;
        logic [pat_pkg::KIND_W-1:0] k;
        logic                       nm;
        if ($urandom_range(0, 99) < 88)
        begin
            p = $urandom_range(0, pool_n - 1);
            a = pool_addr[p];
            k = pool_kind[p];
        end
        else
        begin
            wide = {$urandom(), $urandom()};
            a    = wide[pat_pkg::ADDR_W-1:0];
            k    = pat_pkg::KIND_W'($urandom_range(0, 3));
        end
        nm = ($urandom_range(0, 99) < 12);
        advance_clock();
        send_sighting(a, k, nm, now_ms);
    endtask

    initial
    begin
        logic [63:0]                    wide;
        logic [pat_pkg::INTERVAL_W-1:0] phase_interval[PHASE_COUNT];
        int                             phase_pct     [PHASE_COUNT];
        int                             phase_pool    [PHASE_COUNT];

        rst_n          = 1'b0;
        start          = 1'b0;
        device_address = '0;
        address_kind   = '0;
        name_present   = 1'b0;
        now_time       = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        quiet_cycles   = 0;

        // address pool; some neighbors share an address with another kind
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            wide         = {$urandom(), $urandom()};
            pool_addr[i] = wide[pat_pkg::ADDR_W-1:0];
            pool_kind[i] = pat_pkg::KIND_W'($urandom_range(0, 3));
            if (i % 7 == 1)
            begin
                pool_addr[i] = pool_addr[i - 1];
                pool_kind[i] = pool_kind[i - 1] + 1'b1;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset interval of 200 ms
        send_sighting('0, 2'd0, 1'b0, 48'd1000);                 // new, lowest free slot
        send_sighting(ADDR_ONES, 2'd3, 1'b1, 48'd1000);          // extreme address and kind
        send_sighting('0, 2'd1, 1'b0, 48'd1000);                 // same address, other kind
        send_sighting('0, 2'd0, 1'b0, 48'd1199);                 // one ms short: throttled
        send_sighting('0, 2'd0, 1'b1, 48'd1199);                 // first name breaks through
        send_sighting('0, 2'd0, 1'b1, 48'd1300);                 // name already known
        send_sighting('0, 2'd0, 1'b0, 48'd1399);                 // exactly the interval
        send_sighting('0, 2'd0, 1'b0, 48'd1000);                 // time went back
        send_sighting('0, 2'd0, 1'b1, 48'd900);                  // back in time, but named
        send_sighting(ADDR_ONES, 2'd3, 1'b0, 48'd1000 + HALF_RANGE);      // sign bit set
        send_sighting(ADDR_ONES, 2'd3, 1'b0, 48'd999 + HALF_RANGE);       // largest positive
        send_sighting(48'h5555_5555_5555, 2'd2, 1'b0, 48'hFFFF_FFFF_FFFF); // max time
        send_sighting(48'h5555_5555_5555, 2'd2, 1'b0, 48'd0);   // wraps to diff of one
        send_sighting(48'h5555_5555_5555, 2'd2, 1'b1, 48'd300);
        send_sighting(48'hAAAA_AAAA_AAAA, 2'd1, 1'b1, 48'd300);
        send_sighting(48'hAAAA_AAAA_AAAA, 2'd1, 1'b0, 48'd700);
        send_sighting(48'h0000_0000_0001, 2'd2, 1'b0, 48'h7FFF_FFFF_FFFF);

        // Random phases: interval, sender idling, pool size (above 64 forces eviction)
        phase_interval = '{16'd0, 16'hFFFF, 16'd1,
                           pat_pkg::INTERVAL_W'($urandom_range(2, 65534)), 16'd200};
        phase_pct      = '{0, 71, 0, 10, 71};
        phase_pool     = '{48, 96, 70, 160, 64};
        now_ms         = 48'h10_0000;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_interval(phase_interval[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                sender_gap(phase_pct[ph]);
                send_random_sighting(phase_pool[ph]);
            end
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pat_pkg.sv
src/per_address_report_throttle.sv
bench/per_address_report_throttle_test.sv
